>>> src/qmc_pkg.sv
// ----------------------------------------------------------------------------
// qmc_pkg
// Types, constants and helpers shared by the measure-and-collapse block.
// ----------------------------------------------------------------------------
`default_nettype none
package qmc_pkg;

   localparam int MAX_QUBITS_DEF = 5;
   localparam int AMP_W    = 16;     // Q1.14 component width
   localparam int IDX_W    = 5;      // basis index width
   localparam int ACC_W    = 40;     // exact sum of Q.32 squared magnitudes
   localparam int P0_W     = 24;     // prob0 in Q.16
   localparam int P1_W     = 17;
   localparam int PZ_W     = 18;
   localparam int THR_W    = 16;
   localparam int QC_W     = 3;
   localparam int ROOT_W   = 20;     // sqrt(P * 2^16)
   localparam int QUOT_W   = 33;     // dividend width for the scaling
   localparam int OPND_W   = 40;     // shift register of the iterative unit
   localparam int REM_W    = 24;
   localparam int SQRT_STEPS = OPND_W / 2;
   localparam int CNT_W    = 6;

   typedef enum logic [1:0] {
      CSR_QUBIT_COUNT = 2'd0,
      CSR_ZERO_THR    = 2'd1
   } csr_index_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_MEASURE = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM_WAIT, ST_SUM_RE, ST_SUM_IM, ST_SUM_ADD, ST_PROB,
      ST_BR_START, ST_SQRT, ST_EL_WAIT, ST_EL_CHECK, ST_DIV_RE, ST_DIV_IM,
      ST_OUT
   } state_type;

   typedef enum logic {
      MODE_DIV  = 1'b0,
      MODE_SQRT = 1'b1
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
   } unit_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // Saturates a rounded quotient to a signed Q1.14 component.
   function automatic logic [AMP_W-1:0] sat_amp(input logic [QUOT_W-1:0] q,
                                                input logic neg);
      logic [QUOT_W-1:0] lim;
      logic [AMP_W-1:0]  r;
      lim = QUOT_W'(1) << (AMP_W - 1);
      if (neg) begin
         if (q > lim) r = {1'b1, {(AMP_W-1){1'b0}}};
         else         r = AMP_W'(~q + QUOT_W'(1));
      end else begin
         if (q >= lim) r = {1'b0, {(AMP_W-1){1'b1}}};
         else          r = q[AMP_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/qmc_if.sv
// ----------------------------------------------------------------------------
// qmc_req_if / qmc_rsp_if
// Valid/ready channels for requests and collapsed amplitudes.
// ----------------------------------------------------------------------------
`default_nettype none
interface qmc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [4:0]  amp_index;
   logic signed [15:0] amp_re;
   logic signed [15:0] amp_im;
   logic [2:0]  qubit;
   modport source (output valid, op, amp_index, amp_re, amp_im, qubit, input ready);
   modport sink   (input valid, op, amp_index, amp_re, amp_im, qubit, output ready);
endinterface

interface qmc_rsp_if;
   logic        valid;
   logic        ready;
   logic        branch;
   logic [4:0]  out_index;
   logic signed [15:0] out_re;
   logic signed [15:0] out_im;
   logic [17:0] prob_zero;
   logic        degenerate;
   logic        last;
   modport source (output valid, branch, out_index, out_re, out_im, prob_zero,
                   degenerate, last, input ready);
   modport sink   (input valid, branch, out_index, out_re, out_im, prob_zero,
                   degenerate, last, output ready);
endinterface
`default_nettype wire

>>> src/single_qubit_measure_collapse_top.sv
// A load writes one amplitude into the store. A measure over n qubits first
// sums the squared magnitudes of the zero side, then per branch takes a square
// root (none when degenerate) and per index scales each selected amplitude by division.
// The block takes one item at a time; the square-root/divide unit is shared.
// Reset clears state, qubit count, threshold and prob0, not the amplitude store.
// ----------------------------------------------------------------------------
// single_qubit_measure_collapse_top
// Loads a state vector, measures one qubit and emits both collapsed branches.
// ----------------------------------------------------------------------------
`default_nettype none
module single_qubit_measure_collapse_top import qmc_pkg::*; #(
   parameter int MAX_QUBITS = MAX_QUBITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   qmc_req_if.sink                 req_ch,
   qmc_rsp_if.source               rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [THR_W-1:0]   csr_wdata
);
   localparam int SW    = MAX_QUBITS;
   localparam int DEPTH = 1 << MAX_QUBITS;

   logic [2*AMP_W-1:0] mem [DEPTH];
   logic [2*AMP_W-1:0] rd_ff;

   state_type          state_ff, state_in;
   logic [QC_W-1:0]    qc_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [IDX_W-1:0]   mask_ff, mask_in, last_ff, last_in, idx_ff, idx_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [30:0]        prod_ff, prod_in;
   logic [P0_W-1:0]    p0_ff, p0_in;
   logic [P1_W-1:0]    p1_ff, p1_in;
   logic               branch_ff, branch_in, degen_ff, degen_in;
   logic [ROOT_W-1:0]  s_ff, s_in;
   logic [AMP_W-1:0]   ore_ff, ore_in, oim_ff, oim_in;

   logic [QC_W-1:0]    n_eff;
   logic [ACC_W:0]     rnd;
   logic [P0_W-1:0]    pcur;
   logic               sel, bit_set;
   logic signed [2*AMP_W-1:0] sq;
   logic signed [AMP_W-1:0]   cur;
   logic [AMP_W:0]     ext, mag;
   logic [QUOT_W-1:0]  num;

   unit_req_type       ureq;
   unit_status_type    ustat;
   logic [OPND_W-1:0]  uopnd;
   logic [QUOT_W-1:0]  ures;

   qmc_divsqrt u_unit (
      .clock   (clock),
      .reset   (reset),
      .req     (ureq),
      .opnd    (uopnd),
      .divisor ({s_ff, 1'b0}),
      .status  (ustat),
      .result  (ures)
   );

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready && req_ch.op == OP_LOAD) begin
         mem[req_ch.amp_index[SW-1:0]] <= {req_ch.amp_re, req_ch.amp_im};
      end
      rd_ff <= mem[idx_ff[SW-1:0]];
   end

   always_comb begin
      if (qc_ff == '0)                       n_eff = QC_W'(1);
      else if (qc_ff > QC_W'(MAX_QUBITS))    n_eff = QC_W'(MAX_QUBITS);
      else                                   n_eff = qc_ff;
   end

   assign bit_set = (idx_ff & mask_ff) != '0;
   assign rnd     = {1'b0, acc_ff} + (ACC_W+1)'(32768);
   assign pcur    = branch_ff ? P0_W'(p1_ff) : p0_ff;
   assign cur     = (state_ff == ST_EL_CHECK) ? rd_ff[2*AMP_W-1 -: AMP_W]
                                              : rd_ff[AMP_W-1:0];
   assign ext     = {cur[AMP_W-1], cur};
   assign mag     = ext[AMP_W] ? (~ext + (AMP_W+1)'(1)) : ext;
   assign num     = {mag[AMP_W-1:0], 17'b0} + QUOT_W'(s_ff);

   always_comb begin
      state_in  = state_ff;
      mask_in   = mask_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      branch_in = branch_ff;
      degen_in  = degen_ff;
      s_in      = s_ff;
      ore_in    = ore_ff;
      oim_in    = oim_ff;
      ureq      = '{start: 1'b0, mode: MODE_DIV};
      uopnd     = {num, 7'b0};
      sq        = '0;
      sel       = bit_set == branch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.op == OP_MEASURE && req_ch.qubit < n_eff) begin
               mask_in  = IDX_W'(1) << (n_eff - QC_W'(1) - req_ch.qubit);
               last_in  = IDX_W'((6'd1 << n_eff) - 6'd1);
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SUM_WAIT;
            end
         end
         ST_SUM_WAIT: state_in = ST_SUM_RE;
         ST_SUM_RE: begin
            sq       = $signed(rd_ff[2*AMP_W-1 -: AMP_W]) * $signed(rd_ff[2*AMP_W-1 -: AMP_W]);
            prod_in  = sq[30:0];
            state_in = ST_SUM_IM;
         end
         ST_SUM_IM: begin
            sq       = $signed(rd_ff[AMP_W-1:0]) * $signed(rd_ff[AMP_W-1:0]);
            prod_in  = sq[30:0];
            if (!bit_set) acc_in = acc_ff + ACC_W'({prod_ff, 4'b0});
            state_in = ST_SUM_ADD;
         end
         ST_SUM_ADD: begin
            if (!bit_set) acc_in = acc_ff + ACC_W'({prod_ff, 4'b0});
            if (idx_ff == last_ff) begin
               state_in = ST_PROB;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SUM_WAIT;
            end
         end
         ST_PROB: begin
            p0_in     = rnd[ACC_W-1:16];
            p1_in     = (rnd[ACC_W-1:16] >= P0_W'(65536)) ? '0
                        : P1_W'(P0_W'(65536) - rnd[ACC_W-1:16]);
            branch_in = 1'b0;
            state_in  = ST_BR_START;
         end
         ST_BR_START: begin
            idx_in   = '0;
            degen_in = (pcur == '0) || (pcur < P0_W'(thr_ff));
            if ((pcur == '0) || (pcur < P0_W'(thr_ff))) begin
               state_in = ST_EL_WAIT;
            end else begin
               ureq     = '{start: 1'b1, mode: MODE_SQRT};
               uopnd    = {pcur, 16'b0};
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (ustat.done) begin
               s_in     = ures[ROOT_W-1:0];
               state_in = ST_EL_WAIT;
            end
         end
         ST_EL_WAIT: state_in = ST_EL_CHECK;
         ST_EL_CHECK: begin
            if (sel && !degen_ff) begin
               ureq     = '{start: 1'b1, mode: MODE_DIV};
               state_in = ST_DIV_RE;
            end else begin
               ore_in   = '0;
               oim_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_DIV_RE: begin
            if (ustat.done) begin
               ore_in   = sat_amp(ures, rd_ff[2*AMP_W-1]);
               ureq     = '{start: 1'b1, mode: MODE_DIV};
               state_in = ST_DIV_IM;
            end
         end
         ST_DIV_IM: begin
            if (ustat.done) begin
               oim_in   = sat_amp(ures, rd_ff[AMP_W-1]);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               if (idx_ff == last_ff) begin
                  if (branch_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     branch_in = 1'b1;
                     state_in  = ST_BR_START;
                  end
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_EL_WAIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         qc_ff    <= QC_W'(1);
         thr_ff   <= THR_W'(16);
         p0_ff    <= '0;
      end else begin
         state_ff <= state_in;
         p0_ff    <= p0_in;
         if (csr_we && csr_index == CSR_QUBIT_COUNT) qc_ff  <= csr_wdata[QC_W-1:0];
         if (csr_we && csr_index == CSR_ZERO_THR)    thr_ff <= csr_wdata;
      end
      mask_ff   <= mask_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      p1_ff     <= p1_in;
      branch_ff <= branch_in;
      degen_ff  <= degen_in;
      s_ff      <= s_in;
      ore_ff    <= ore_in;
      oim_ff    <= oim_in;
   end

   assign req_ch.ready      = state_ff == ST_IDLE;
   assign rsp_ch.valid      = state_ff == ST_OUT;
   assign rsp_ch.branch     = branch_ff;
   assign rsp_ch.out_index  = idx_ff;
   assign rsp_ch.out_re     = ore_ff;
   assign rsp_ch.out_im     = oim_ff;
   assign rsp_ch.prob_zero  = (p0_ff > P0_W'(262143)) ? '1 : p0_ff[PZ_W-1:0];
   assign rsp_ch.degenerate = degen_ff;
   assign rsp_ch.last       = branch_ff && (idx_ff == last_ff);

   // A degenerate branch never carries a non-zero amplitude.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |-> rsp_ch.out_re == '0 && rsp_ch.out_im == '0)
      else $error("degenerate beat with non-zero amplitude");
   a_last_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last |-> rsp_ch.branch)
      else $error("last flagged outside branch one");
   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ustat.busy)
      else $error("shared unit busy while idle");
endmodule
`default_nettype wire

>>> src/qmc_divsqrt.sv
// ----------------------------------------------------------------------------
// qmc_divsqrt
// Shared restoring unit: integer square root two bits a cycle, or division
// one quotient bit a cycle, through a single compare-and-subtract.
// ----------------------------------------------------------------------------
`default_nettype none
module qmc_divsqrt import qmc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire unit_req_type        req,
   input  wire logic [OPND_W-1:0]   opnd,     // radicand, or dividend left-aligned
   input  wire logic [ROOT_W:0]     divisor,
   output      unit_status_type     status,
   output      logic [QUOT_W-1:0]   result
);
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   unit_mode_type       mode_ff, mode_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [OPND_W-1:0]   op_ff, op_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [QUOT_W-1:0]   res_ff, res_in;
   logic [REM_W-1:0]    shifted, trial;
   logic [REM_W:0]      diff;
   logic                ge;

   always_comb begin
      if (mode_ff == MODE_SQRT) begin
         shifted = {rem_ff[REM_W-3:0], op_ff[OPND_W-1 -: 2]};
         trial   = {res_ff[REM_W-3:0], 2'b01};
      end else begin
         shifted = {rem_ff[REM_W-2:0], op_ff[OPND_W-1]};
         trial   = REM_W'(divisor);
      end
      diff = {1'b0, shifted} - {1'b0, trial};
      ge   = !diff[REM_W];

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         mode_in = req.mode;
         op_in   = opnd;
         rem_in  = '0;
         res_in  = '0;
         cnt_in  = (req.mode == MODE_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(QUOT_W);
      end else if (busy_ff) begin
         rem_in = ge ? diff[REM_W-1:0] : shifted;
         res_in = {res_ff[QUOT_W-2:0], ge};
         op_in  = (mode_ff == MODE_SQRT) ? {op_ff[OPND_W-3:0], 2'b00}
                                         : {op_ff[OPND_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign status = '{busy: busy_ff, done: done_ff};
   assign result = res_ff;
endmodule
`default_nettype wire
